/* sv/wpf_pkg.sv */
// ----------------------------------------------------------------------------
// wpf_pkg: shared types and constants for the weighted position fusion block
// Item types for the request and response channels, mode and status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package wpf_pkg;
   localparam int StationCountDefault = 1024;
   localparam int FracBitsDefault = 16;
   localparam int StationBits = 10;
   localparam int WordBits = 32;

   localparam logic [1:0] MODE_FUSE   = 2'd0;
   localparam logic [1:0] MODE_SET    = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [1:0] STATUS_FUSED   = 2'd0;
   localparam logic [1:0] STATUS_SET     = 2'd1;
   localparam logic [1:0] STATUS_CLEARED = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [9:0]         station;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [31:0]        err_x;
      logic [31:0]        err_y;
      logic [31:0]        err_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic [31:0]        out_err_x;
      logic [31:0]        out_err_y;
      logic [31:0]        out_err_z;
      logic [31:0]        total_error;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_DIV,
      OP_SQRT
   } op_type;

   typedef struct packed {
      logic        start;
      op_type      op;
      logic [65:0] num;
      logic [32:0] den;
   } unit_cmd_type;
endpackage
`default_nettype wire

/* sv/weighted_position_fusion.sv */
// ----------------------------------------------------------------------------
// weighted_position_fusion: survey station table with weighted fusion
// Request items carry a mode, a station index and a measured position and
// error per axis. Each accepted item of mode fuse, set or clear gives one
// response item with the station's resulting position, errors, total error
// and a status; mode 3 gives no response.
// One item is worked at a time; req_ready is low while it is in progress.
// A fuse with nonzero errors on every axis works, per axis, a table access
// and two divisions, then a sum of squares over the axes and a square root.
// An axis with a zero error skips its divisions. A set skips all divisions,
// and a clear only marks the station unset. All divisions and the square
// root go through the one shared bit-serial divide and square root unit; the
// next item can be accepted once the response is marked valid.
// The response is held in an output register until rsp_ready. Meanwhile the
// next item is accepted and worked up to its own response, where it waits.
// After reset, a clearing pass over all STATION_COUNT stations marks every
// station unset; req_ready stays low during it.
// ----------------------------------------------------------------------------
`default_nettype none
module weighted_position_fusion
   import wpf_pkg::*;
#(
   parameter int STATION_COUNT = StationCountDefault,
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);
   localparam int SB = $clog2(STATION_COUNT);
   localparam int DEPTH = 3 * STATION_COUNT;
   localparam int AB = $clog2(DEPTH);
   localparam logic [31:0] FracUnit = 32'(1) << FRAC_BITS;
   localparam int StShift = StationBits + SB;
   localparam longint StRecip =
      ((longint'(1) << StShift) + longint'(STATION_COUNT) - 1) / longint'(STATION_COUNT);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_READ, S_WAIT, S_LOAD, S_DIVP, S_DIVE, S_WRITE,
      S_SQ, S_SQRT, S_DONE
   } state_type;

   state_type   state_ff;
   req_type     req_ff;
   logic [SB-1:0] st_ff;
   logic [SB-1:0] clr_ff;
   logic [1:0]  axis_ff;
   logic        wait_ff;
   logic [31:0] p_ff [3];
   logic [31:0] e_ff [3];
   logic [65:0] sum_ff;
   logic        sat_ff;
   logic        fused_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;
   unit_cmd_type cmd;
   logic        busy;
   logic [65:0] ures;
   logic        ram_we;
   logic [AB-1:0] ram_addr;
   logic [31:0] prd, erd;
   logic [31:0] mp, me, cp, ce;
   logic        neg;
   logic [32:0] gap;
   logic [32:0] esum;
   logic [63:0] sq;
   logic [66:0] nsum;
   logic        flag_we;
   logic        flag_wd;
   logic        flag_rd;
   logic [SB-1:0] flag_addr;
   logic [47:0] st_prod;
   logic [StationBits-1:0] st_quo;
   logic [31:0] st_rem;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign st_prod = 48'(req_data.station) * 48'(StRecip);
   assign st_quo = StationBits'(st_prod >> StShift);
   assign st_rem = 32'(req_data.station) - 32'(st_quo) * 32'(STATION_COUNT);

   always_comb begin
      case (axis_ff)
         2'd0: begin mp = req_ff.pos_x; me = req_ff.err_x; end
         2'd1: begin mp = req_ff.pos_y; me = req_ff.err_y; end
         default: begin mp = req_ff.pos_z; me = req_ff.err_z; end
      endcase
      cp = (state_ff == S_LOAD) ? prd : p_ff[axis_ff];
      ce = (state_ff == S_LOAD) ? erd : e_ff[axis_ff];
      neg = $signed(mp) < $signed(cp);
      gap = neg ? ({cp[31], cp} - {mp[31], mp}) : ({mp[31], mp} - {cp[31], cp});
      esum = {1'b0, ce} + {1'b0, me};
      sq = ce * ce;
      nsum = {1'b0, sum_ff} + {3'b0, sq};
   end

   assign ram_addr = AB'(st_ff) * AB'(3) + AB'(axis_ff);
   assign ram_we = (state_ff == S_WRITE);

   wpf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_pos (
      .clock, .wr_en(ram_we), .addr(ram_addr), .wr_data(cp), .rd_data(prd));
   wpf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_err (
      .clock, .wr_en(ram_we), .addr(ram_addr), .wr_data(ce), .rd_data(erd));

   assign flag_addr = (state_ff == S_CLEAR) ? clr_ff : st_ff;
   assign flag_wd = (state_ff == S_WAIT);
   assign flag_we = (state_ff == S_CLEAR)
                 || (state_ff == S_READ && req_ff.mode == MODE_CLEAR)
                 || (state_ff == S_WAIT && axis_ff == 2'd0);

   wpf_ram #(.WIDTH(1), .DEPTH(STATION_COUNT)) u_flag (
      .clock, .wr_en(flag_we), .addr(flag_addr), .wr_data(flag_wd), .rd_data(flag_rd));

   always_comb begin
      cmd.start = 1'b0;
      cmd.op = OP_DIV;
      cmd.num = 66'(gap) * 66'(ce);
      cmd.den = esum;
      if (state_ff == S_LOAD && fused_ff && ce != 32'd0 && me != 32'd0) begin
         cmd.start = 1'b1;
      end else if (state_ff == S_DIVP && !busy && !wait_ff) begin
         cmd.start = 1'b1;
         cmd.num = 66'(ce) * 66'(me);
      end else if (state_ff == S_SQ && axis_ff == 2'd2) begin
         cmd.start = !(nsum[66] || sat_ff);
         cmd.op = OP_SQRT;
         cmd.num = nsum[65:0];
      end
   end

   wpf_unit u_unit (.clock, .reset, .cmd, .busy, .result(ures));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         wait_ff <= 1'b0;
      end else begin
         wait_ff <= cmd.start;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + SB'(1);
               if (clr_ff == SB'(STATION_COUNT - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid && req_ready && req_data.mode != MODE_UNUSED) begin
                  req_ff <= req_data;
                  st_ff <= SB'(st_rem);
                  axis_ff <= 2'd0;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               if (req_ff.mode == MODE_CLEAR) begin
                  if (!rsp_valid_ff) begin
                     rsp_ff <= '{32'sd0, 32'sd0, 32'sd0, '1, '1, '1, '1, STATUS_CLEARED};
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end
               end else begin
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               if (axis_ff == 2'd0) fused_ff <= (req_ff.mode == MODE_FUSE) && flag_rd;
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               if (fused_ff) begin
                  p_ff[axis_ff] <= prd;
                  e_ff[axis_ff] <= erd;
                  if (cmd.start) state_ff <= S_DIVP;
                  else state_ff <= S_WRITE;
               end else begin
                  p_ff[axis_ff] <= mp;
                  e_ff[axis_ff] <= me;
                  state_ff <= S_WRITE;
               end
            end
            S_DIVP: begin
               if (!busy && !wait_ff) begin
                  p_ff[axis_ff] <= neg ? cp - ures[31:0] : cp + ures[31:0];
                  state_ff <= S_DIVE;
               end
            end
            S_DIVE: begin
               if (!busy && !wait_ff) begin
                  e_ff[axis_ff] <= ures[31:0];
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               if (axis_ff == 2'd2) begin
                  axis_ff <= 2'd0;
                  sum_ff <= '0;
                  sat_ff <= 1'b0;
                  state_ff <= S_SQ;
               end else begin
                  axis_ff <= axis_ff + 2'd1;
                  state_ff <= S_WAIT;
               end
            end
            S_SQ: begin
               sum_ff <= nsum[65:0];
               sat_ff <= sat_ff || nsum[66];
               if (axis_ff == 2'd2) state_ff <= S_SQRT;
               else axis_ff <= axis_ff + 2'd1;
            end
            S_SQRT: begin
               if (!busy && !wait_ff && !rsp_valid_ff) begin
                  rsp_ff.out_x <= p_ff[0];
                  rsp_ff.out_y <= p_ff[1];
                  rsp_ff.out_z <= p_ff[2];
                  rsp_ff.out_err_x <= e_ff[0];
                  rsp_ff.out_err_y <= e_ff[1];
                  rsp_ff.out_err_z <= e_ff[2];
                  rsp_ff.total_error <= (sat_ff || ures[65:32] != '0) ? '1 : ures[31:0];
                  rsp_ff.status <= fused_ff ? STATUS_FUSED : STATUS_SET;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   logic unused_ok;
   assign unused_ok = ^FracUnit;
endmodule
`default_nettype wire

/* sv/wpf_ram.sv */
// ----------------------------------------------------------------------------
// wpf_ram: generic single port RAM
// One address per cycle: an optional write, and a read of the old data, registered.
// ----------------------------------------------------------------------------
`default_nettype none
module wpf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 3072
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

/* sv/wpf_unit.sv */
// ----------------------------------------------------------------------------
// wpf_unit: shared iterative divider and square root unit
// Restoring division of a 66-bit numerator by a 33-bit divisor, one quotient
// bit per cycle, and a digit-by-digit square root of a 66-bit radicand, one
// result bit per cycle. Results are floored.
// ----------------------------------------------------------------------------
`default_nettype none
module wpf_unit
   import wpf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire unit_cmd_type cmd,
   output logic              busy,
   output logic [65:0]       result
);
   logic [6:0]  count_ff;
   op_type      op_ff;
   logic [65:0] num_ff;
   logic [32:0] den_ff;
   logic [33:0] rem_ff;
   logic [67:0] srem_ff;
   logic [65:0] quo_ff;
   logic [33:0] rem_sh;
   logic [67:0] srem_sh;
   logic [67:0] trial;

   assign busy = (count_ff != 7'd0);
   assign result = quo_ff;
   assign rem_sh = {rem_ff[32:0], num_ff[65]};
   assign srem_sh = {srem_ff[65:0], num_ff[65:64]};
   assign trial = {quo_ff[65:0], 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 7'd0;
      end else if (cmd.start) begin
         op_ff <= cmd.op;
         num_ff <= cmd.num;
         den_ff <= cmd.den;
         rem_ff <= '0;
         srem_ff <= '0;
         quo_ff <= '0;
         count_ff <= (cmd.op == OP_DIV) ? 7'd66 : 7'd33;
      end else if (busy) begin
         count_ff <= count_ff - 7'd1;
         if (op_ff == OP_DIV) begin
            num_ff <= {num_ff[64:0], 1'b0};
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_ff <= rem_sh - {1'b0, den_ff};
               quo_ff <= {quo_ff[64:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[64:0], 1'b0};
            end
         end else begin
            num_ff <= {num_ff[63:0], 2'b00};
            if (srem_sh >= trial) begin
               srem_ff <= srem_sh - trial;
               quo_ff <= {quo_ff[64:0], 1'b1};
            end else begin
               srem_ff <= srem_sh;
               quo_ff <= {quo_ff[64:0], 1'b0};
            end
         end
      end
   end
endmodule
`default_nettype wire
